// ===== rtl/core/aidt_pkg.sv =====
package aidt_pkg;

  typedef enum logic [2:0] {
    MODE_HEAD    = 3'd0,
    MODE_MAIN    = 3'd1,
    MODE_COMMENT = 3'd2,
    MODE_DASH    = 3'd3,
    MODE_ATOM    = 3'd4,
    MODE_STRING  = 3'd5,
    MODE_STRESC  = 3'd6,
    MODE_ERROR   = 3'd7
  } mode_t;

  typedef enum logic [3:0] {
    KIND_OPEN      = 4'd0,
    KIND_CLOSE     = 4'd1,
    KIND_CONV      = 4'd2,
    KIND_MAP       = 4'd3,
    KIND_LIST      = 4'd4,
    KIND_STRING    = 4'd5,
    KIND_ESCSTRING = 4'd6,
    KIND_ATOM      = 4'd7,
    KIND_INDENT    = 4'd8,
    KIND_TAG       = 4'd9,
    KIND_REF       = 4'd10,
    KIND_END       = 4'd11,
    KIND_ERR_BREAK = 4'd12,
    KIND_ERR_OPEN  = 4'd13
  } kind_t;

  typedef enum logic [1:0] {
    HEAD_PLAIN = 2'd0,
    HEAD_AMP   = 2'd1,
    HEAD_STAR  = 2'd2
  } head_t;

  typedef enum logic {
    CMD_DATA = 1'b0,
    CMD_END  = 1'b1
  } cmd_t;

  typedef struct packed {
    kind_t       kind;
    logic [31:0] start;
    logic [31:0] stop;
    logic [15:0] indent;
    logic        sq;
    logic        last;
  } tok_t;

  localparam logic [4:0] TAB_WIDTH_RESET = 5'd4;
  localparam int unsigned Q_DEPTH = 4;

  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_DQUOTE = 8'h22;
  localparam logic [7:0] CH_HASH   = 8'h23;
  localparam logic [7:0] CH_DOLLAR = 8'h24;
  localparam logic [7:0] CH_AMP    = 8'h26;
  localparam logic [7:0] CH_SQUOTE = 8'h27;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_COMMA  = 8'h2C;
  localparam logic [7:0] CH_DASH   = 8'h2D;
  localparam logic [7:0] CH_COLON  = 8'h3A;
  localparam logic [7:0] CH_LBRACK = 8'h5B;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_RBRACK = 8'h5D;
  localparam logic [7:0] CH_LBRACE = 8'h7B;
  localparam logic [7:0] CH_RBRACE = 8'h7D;

endpackage

// ===== rtl/core/aidt_scan.sv =====
module aidt_scan #(
  parameter int OFFSET_BITS = 32,
  parameter int INDENT_BITS = 16
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              tab_width_we,
  input  logic [4:0]        tab_width_wdata,
  input  logic              step,
  input  logic              command,
  input  logic [7:0]        data_byte,
  output logic [1:0]        tok_count,
  output aidt_pkg::tok_t    tok0,
  output aidt_pkg::tok_t    tok1
);
  import aidt_pkg::*;

  localparam int OW = (OFFSET_BITS > 32) ? OFFSET_BITS : 32;
  localparam int IW = (INDENT_BITS > 16) ? INDENT_BITS : 17;
  localparam int SW = ((INDENT_BITS > 5) ? INDENT_BITS : 5) + 1;
  localparam logic [INDENT_BITS-1:0] INDENT_MAX = {INDENT_BITS{1'b1}};

  logic [4:0]             tab_width;
  mode_t                  mode, mode_next;
  logic [OFFSET_BITS-1:0] pos, pos_next;
  logic [OFFSET_BITS-1:0] tbegin, tbegin_next;
  logic [INDENT_BITS-1:0] indent, indent_next;
  logic                   qsingle, qsingle_next;
  logic                   esc, esc_next;
  head_t                  head, head_next;
  logic                   all_hex, all_hex_next;
  logic                   has_digits, has_digits_next;

  logic                   pre_v, main_v, do_main;
  tok_t                   pre_tok, main_tok;
  logic [OFFSET_BITS-1:0] pos_inc;
  logic [SW-1:0]          indent_sum;
  kind_t                  atom_kind;

  function automatic logic [31:0] off32(input logic [OFFSET_BITS-1:0] x);
    logic [OW-1:0] e;
    e = OW'(x);
    return e[31:0];
  endfunction

  function automatic logic [15:0] sat16(input logic [INDENT_BITS-1:0] x);
    logic [IW-1:0] e;
    e = IW'(x);
    return (e > IW'(17'h0FFFF)) ? 16'hFFFF : e[15:0];
  endfunction

  function automatic tok_t mk_tok(input kind_t k, input logic [OFFSET_BITS-1:0] a,
                                  input logic [OFFSET_BITS-1:0] z,
                                  input logic [15:0] w, input logic s);
    tok_t t;
    t.kind   = k;
    t.start  = off32(a);
    t.stop   = off32(z);
    t.indent = w;
    t.sq     = s;
    t.last   = 1'b0;
    return t;
  endfunction

  function automatic logic is_blank(input logic [7:0] b);
    return b == CH_SPACE || b == CH_TAB || b == CH_CR || b == CH_LF;
  endfunction

  function automatic logic is_sep(input logic [7:0] b);
    return is_blank(b) || b == CH_COMMA || b == CH_LBRACE || b == CH_RBRACE ||
           b == CH_LBRACK || b == CH_RBRACK || b == CH_DOLLAR || b == CH_COLON ||
           b == CH_DQUOTE || b == CH_SQUOTE;
  endfunction

  function automatic logic is_hex(input logic [7:0] b);
    return (b >= 8'h30 && b <= 8'h39) || (b >= 8'h61 && b <= 8'h66) ||
           (b >= 8'h41 && b <= 8'h46);
  endfunction

  assign pos_inc    = pos + OFFSET_BITS'(1);
  assign indent_sum = SW'(indent) + SW'((data_byte == CH_SPACE) ? 5'd1 : tab_width);

  always_comb begin
    atom_kind = KIND_ATOM;
    if (has_digits && all_hex) begin
      if (head == HEAD_AMP) atom_kind = KIND_TAG;
      else if (head == HEAD_STAR) atom_kind = KIND_REF;
    end
  end

  always_comb begin
    mode_next       = mode;
    pos_next        = pos;
    tbegin_next     = tbegin;
    indent_next     = indent;
    qsingle_next    = qsingle;
    esc_next        = esc;
    head_next       = head;
    all_hex_next    = all_hex;
    has_digits_next = has_digits;
    pre_v    = 1'b0;
    main_v   = 1'b0;
    do_main  = 1'b0;
    pre_tok  = mk_tok(KIND_ATOM, tbegin, pos, 16'd0, 1'b0);
    main_tok = mk_tok(KIND_END, pos, pos, 16'd0, 1'b0);

    if (command == CMD_END) begin
      if (mode == MODE_DASH) begin
        pre_v   = 1'b1;
        pre_tok = mk_tok(KIND_LIST, tbegin, pos, 16'd0, 1'b0);
      end else if (mode == MODE_ATOM) begin
        pre_v   = 1'b1;
        pre_tok = mk_tok(atom_kind, tbegin, pos, 16'd0, 1'b0);
      end
      if (mode == MODE_STRING || mode == MODE_STRESC) begin
        main_v   = 1'b1;
        main_tok = mk_tok(KIND_ERR_OPEN, tbegin, pos, 16'd0, 1'b0);
      end else if (mode != MODE_ERROR) begin
        main_v = 1'b1;
      end
      mode_next       = MODE_HEAD;
      pos_next        = '0;
      tbegin_next     = '0;
      indent_next     = '0;
      qsingle_next    = 1'b0;
      esc_next        = 1'b0;
      head_next       = HEAD_PLAIN;
      all_hex_next    = 1'b1;
      has_digits_next = 1'b0;
    end else begin
      pos_next = pos_inc;
      unique case (mode)
        MODE_HEAD: begin
          if (data_byte == CH_SPACE || data_byte == CH_TAB) begin
            indent_next = (indent_sum > SW'(INDENT_MAX)) ? INDENT_MAX
                                                         : indent_sum[INDENT_BITS-1:0];
          end else if (data_byte == CH_CR || data_byte == CH_LF) begin
            tbegin_next = pos_inc;
            indent_next = '0;
          end else if (data_byte == CH_HASH) begin
            mode_next = MODE_COMMENT;
          end else begin
            pre_v       = 1'b1;
            pre_tok     = mk_tok(KIND_INDENT, tbegin, pos, sat16(indent), 1'b0);
            indent_next = '0;
            do_main     = 1'b1;
          end
        end
        MODE_MAIN: do_main = 1'b1;
        MODE_COMMENT: begin
          if (data_byte == CH_CR || data_byte == CH_LF) begin
            mode_next   = MODE_HEAD;
            tbegin_next = pos_inc;
            indent_next = '0;
          end
        end
        MODE_DASH: begin
          if (data_byte == CH_DASH) begin
            mode_next = MODE_DASH;
          end else if (is_blank(data_byte)) begin
            pre_v   = 1'b1;
            pre_tok = mk_tok(KIND_LIST, tbegin, pos, 16'd0, 1'b0);
            do_main = 1'b1;
          end else if (is_sep(data_byte)) begin
            pre_v   = 1'b1;
            pre_tok = mk_tok(KIND_ATOM, tbegin, pos, 16'd0, 1'b0);
            do_main = 1'b1;
          end else begin
            // dashes turn out to lead a plain atom
            mode_next       = MODE_ATOM;
            head_next       = HEAD_PLAIN;
            all_hex_next    = 1'b1;
            has_digits_next = 1'b1;
          end
        end
        MODE_ATOM: begin
          if (is_sep(data_byte)) begin
            pre_v   = 1'b1;
            pre_tok = mk_tok(atom_kind, tbegin, pos, 16'd0, 1'b0);
            do_main = 1'b1;
          end else begin
            has_digits_next = 1'b1;
            if (!is_hex(data_byte)) all_hex_next = 1'b0;
          end
        end
        MODE_STRING: begin
          if (data_byte == (qsingle ? CH_SQUOTE : CH_DQUOTE)) begin
            main_v    = 1'b1;
            main_tok  = mk_tok(esc ? KIND_ESCSTRING : KIND_STRING, tbegin, pos,
                               16'd0, 1'b0);
            mode_next = MODE_MAIN;
          end else if (data_byte == CH_CR || data_byte == CH_LF) begin
            main_v    = 1'b1;
            main_tok  = mk_tok(KIND_ERR_BREAK, tbegin, pos, 16'd0, 1'b0);
            mode_next = MODE_ERROR;
          end else if (data_byte == CH_BSLASH) begin
            esc_next  = 1'b1;
            mode_next = MODE_STRESC;
          end
        end
        MODE_STRESC: mode_next = MODE_STRING;
        default: mode_next = MODE_ERROR;
      endcase

      if (do_main) begin
        mode_next = MODE_MAIN;
        unique case (data_byte) inside
          CH_HASH: mode_next = MODE_COMMENT;
          CH_CR, CH_LF: begin
            mode_next   = MODE_HEAD;
            tbegin_next = pos_inc;
            indent_next = '0;
          end
          CH_SPACE, CH_TAB, CH_COMMA: ;
          CH_LBRACE, CH_LBRACK: begin
            main_v   = 1'b1;
            main_tok = mk_tok(KIND_OPEN, pos, pos_inc, 16'd0, data_byte == CH_LBRACK);
          end
          CH_RBRACE, CH_RBRACK: begin
            main_v   = 1'b1;
            main_tok = mk_tok(KIND_CLOSE, pos, pos_inc, 16'd0, data_byte == CH_RBRACK);
          end
          CH_DOLLAR: begin
            main_v   = 1'b1;
            main_tok = mk_tok(KIND_CONV, pos, pos_inc, 16'd0, 1'b0);
          end
          CH_COLON: begin
            main_v   = 1'b1;
            main_tok = mk_tok(KIND_MAP, pos, pos_inc, 16'd0, 1'b0);
          end
          CH_DQUOTE, CH_SQUOTE: begin
            mode_next    = MODE_STRING;
            tbegin_next  = pos_inc;
            qsingle_next = (data_byte == CH_SQUOTE);
            esc_next     = 1'b0;
          end
          CH_DASH: begin
            mode_next   = MODE_DASH;
            tbegin_next = pos;
          end
          default: begin
            mode_next       = MODE_ATOM;
            tbegin_next     = pos;
            head_next       = (data_byte == CH_AMP)  ? HEAD_AMP :
                              (data_byte == CH_STAR) ? HEAD_STAR : HEAD_PLAIN;
            all_hex_next    = 1'b1;
            has_digits_next = 1'b0;
          end
        endcase
      end
    end
  end

  // flushed token goes first, the byte's own token second
  always_comb begin
    tok_count = 2'(pre_v) + 2'(main_v);
    tok0      = pre_v ? pre_tok : main_tok;
    tok0.last = !(pre_v && main_v);
    tok1      = main_tok;
    tok1.last = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tab_width  <= TAB_WIDTH_RESET;
      mode       <= MODE_HEAD;
      pos        <= '0;
      tbegin     <= '0;
      indent     <= '0;
      qsingle    <= 1'b0;
      esc        <= 1'b0;
      head       <= HEAD_PLAIN;
      all_hex    <= 1'b1;
      has_digits <= 1'b0;
    end else begin
      if (tab_width_we) tab_width <= tab_width_wdata;
      if (step) begin
        mode       <= mode_next;
        pos        <= pos_next;
        tbegin     <= tbegin_next;
        indent     <= indent_next;
        qsingle    <= qsingle_next;
        esc        <= esc_next;
        head       <= head_next;
        all_hex    <= all_hex_next;
        has_digits <= has_digits_next;
      end
    end
  end

endmodule

// ===== rtl/core/aidt_queue.sv =====
module aidt_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic [1:0]      push_count,
  input  aidt_pkg::tok_t  push0,
  input  aidt_pkg::tok_t  push1,
  output logic            room,
  output logic            pop_valid,
  input  logic            pop_ready,
  output aidt_pkg::tok_t  pop_tok
);
  import aidt_pkg::*;

  localparam int PW = $clog2(Q_DEPTH);
  localparam int CW = $clog2(Q_DEPTH + 1);

  tok_t          mem [Q_DEPTH];
  logic [PW-1:0] wr_ptr, rd_ptr;
  logic [CW-1:0] count;
  logic          pop;

  assign room      = count <= CW'(Q_DEPTH - 2);
  assign pop_valid = count != '0;
  assign pop_tok   = mem[rd_ptr];
  assign pop       = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (push_count != 2'd0) mem[wr_ptr] <= push0;
    if (push_count == 2'd2) mem[wr_ptr + PW'(1)] <= push1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + PW'(push_count);
      if (pop) rd_ptr <= rd_ptr + PW'(1);
      count <= count + CW'(push_count) - CW'(pop);
    end
  end

endmodule

// ===== rtl/core/indent_aware_data_tokenizer_unit.sv =====
// channel   direction  handshake            payload
// in        input      in_valid / in_ready   command, data_byte
// out       output     out_valid / out_ready token_kind, start_offset, stop_offset,
//                                            indent_width, square_bracket, last_of_run
// config    input      tab_width_we          tab_width_wdata
//
// One byte is taken per cycle while in_ready is high; its tokens are written into a
// four-entry token queue as the byte is taken and reach the output once older tokens drain.
// A byte may push two tokens; the queue drains one per cycle while out_ready is high.
// in_ready is high while the queue has at least two free entries.
// rst is synchronous: scan state to line head, offsets to 0, tab_width to 4, queue empty.
// A stalled output holds its token and fills the queue, then in_ready drops.
module indent_aware_data_tokenizer_unit #(
  parameter int OFFSET_BITS = 32,
  parameter int INDENT_BITS = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        tab_width_we,
  input  logic [4:0]  tab_width_wdata,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        command,
  input  logic [7:0]  data_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [3:0]  token_kind,
  output logic [31:0] start_offset,
  output logic [31:0] stop_offset,
  output logic [15:0] indent_width,
  output logic        square_bracket,
  output logic        last_of_run
);
  import aidt_pkg::*;

  logic       step;
  logic [1:0] tok_count;
  tok_t       tok0, tok1, head_tok;

  assign step = in_valid && in_ready;

  aidt_scan #(
    .OFFSET_BITS(OFFSET_BITS),
    .INDENT_BITS(INDENT_BITS)
  ) u_scan (
    .clk             (clk),
    .rst             (rst),
    .tab_width_we    (tab_width_we),
    .tab_width_wdata (tab_width_wdata),
    .step            (step),
    .command         (command),
    .data_byte       (data_byte),
    .tok_count       (tok_count),
    .tok0            (tok0),
    .tok1            (tok1)
  );

  aidt_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_count (step ? tok_count : 2'd0),
    .push0      (tok0),
    .push1      (tok1),
    .room       (in_ready),
    .pop_valid  (out_valid),
    .pop_ready  (out_ready),
    .pop_tok    (head_tok)
  );

  assign token_kind     = head_tok.kind;
  assign start_offset   = head_tok.start;
  assign stop_offset    = head_tok.stop;
  assign indent_width   = head_tok.indent;
  assign square_bracket = head_tok.sq;
  assign last_of_run    = head_tok.last;

endmodule

// ===== rtl/core/aidt_checker.sv =====
module aidt_checker (
  input logic        clk,
  input logic        rst,
  input logic        out_valid,
  input logic        out_ready,
  input logic [3:0]  token_kind,
  input logic [31:0] start_offset,
  input logic [31:0] stop_offset,
  input logic [15:0] indent_width,
  input logic        square_bracket,
  input logic        last_of_run
);
  import aidt_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("output item dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> $stable(token_kind) && $stable(start_offset) &&
                                $stable(stop_offset) && $stable(last_of_run))
    else $error("output item changed while stalled");

  a_end_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && (token_kind == KIND_END || token_kind == KIND_ERR_OPEN) |-> last_of_run)
    else $error("end of input token not last of its run");

  a_indent_only: assert property (@(posedge clk) disable iff (rst)
    out_valid && token_kind != KIND_INDENT |-> indent_width == 16'd0)
    else $error("indent width on a non-indent token");

  a_bracket_only: assert property (@(posedge clk) disable iff (rst)
    out_valid && square_bracket |-> token_kind == KIND_OPEN || token_kind == KIND_CLOSE)
    else $error("square bracket flag on a non-bracket token");

endmodule

bind indent_aware_data_tokenizer_unit aidt_checker u_aidt_checker (.*);

// ===== verif/tb_top.sv =====
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import aidt_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int RANDOM_ITEMS = 1050;
  localparam int MAX_PRINTS = 100;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        tab_width_we = 1'b0;
  logic [4:0]  tab_width_wdata = 5'd0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic        command = 1'b0;
  logic [7:0]  data_byte = 8'd0;
  logic        out_valid;
  logic        out_ready = 1'b1;
  logic [3:0]  token_kind;
  logic [31:0] start_offset;
  logic [31:0] stop_offset;
  logic [15:0] indent_width;
  logic        square_bracket;
  logic        last_of_run;

  indent_aware_data_tokenizer_unit DUT (
    .clk            (clk),
    .rst            (rst),
    .tab_width_we   (tab_width_we),
    .tab_width_wdata(tab_width_wdata),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .command        (command),
    .data_byte      (data_byte),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .token_kind     (token_kind),
    .start_offset   (start_offset),
    .stop_offset    (stop_offset),
    .indent_width   (indent_width),
    .square_bracket (square_bracket),
    .last_of_run    (last_of_run)
  );

  always #5 clk = ~clk;

  // scanner shadow state
  mode_t       lex_mode;
  logic [31:0] cur_pos;
  logic [31:0] tok_start;
  logic [15:0] col_count;
  logic        single_quote;
  logic        seen_escape;
  head_t       lead;
  logic        only_hex;
  logic        has_body;
  logic [4:0]  tab_cols;

  tok_t        tokens_due[$];
  tok_t        held_tok;
  bit          have_held;

  int          err_count = 0;
  int          items_sent = 0;
  int          in_gap_pct = 0;
  int          out_stall_pct = 0;
  bit          no_idle = 1'b0;
  int          stall_left = 0;
  int unsigned cycle_count = 0;

  always @(posedge clk) cycle_count <= cycle_count + 1;

  initial begin
    wait (cycle_count == CYCLE_LIMIT);
    $display("indent_aware_data_tokenizer_unit verification failed");
    $finish;
  end

  always @(posedge clk) begin
    if (rst || no_idle) begin
      out_ready <= 1'b1;
    end else if (stall_left > 0) begin
      out_ready <= 1'b0;
      stall_left = stall_left - 1;
    end else if ($urandom_range(0, 99) < out_stall_pct) begin
      stall_left = $urandom_range(0, 4);
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  task automatic report_mismatch(string what, logic [31:0] got_val, logic [31:0] exp_val);
    err_count++;
    if (err_count <= MAX_PRINTS)
      $display("MISMATCH %s: got %0h expected %0h (cycle %0d)", what, got_val, exp_val,
               cycle_count);
  endtask

  always @(posedge clk) begin : check_tokens
    tok_t want;
    if (!rst && out_valid && out_ready) begin
      if (tokens_due.size() == 0) begin
        report_mismatch("token with none expected, kind", 32'(token_kind), 32'd0);
      end else begin
        want = tokens_due.pop_front();
        if (token_kind !== want.kind)
          report_mismatch("token_kind", 32'(token_kind), 32'(want.kind));
        if (start_offset !== want.start) report_mismatch("start_offset", start_offset, want.start);
        if (stop_offset !== want.stop) report_mismatch("stop_offset", stop_offset, want.stop);
        if (indent_width !== want.indent)
          report_mismatch("indent_width", 32'(indent_width), 32'(want.indent));
        if (square_bracket !== want.sq)
          report_mismatch("square_bracket", 32'(square_bracket), 32'(want.sq));
        if (last_of_run !== want.last)
          report_mismatch("last_of_run", 32'(last_of_run), 32'(want.last));
      end
    end
  end

  // ---------------- token predictor ----------------

  function automatic bit is_space_byte(logic [7:0] b);
    return b == CH_SPACE || b == CH_TAB || b == CH_CR || b == CH_LF;
  endfunction

  function automatic bit is_separator(logic [7:0] b);
    return is_space_byte(b) || b == CH_COMMA || b == CH_LBRACE || b == CH_RBRACE ||
           b == CH_LBRACK || b == CH_RBRACK || b == CH_DOLLAR || b == CH_COLON ||
           b == CH_DQUOTE || b == CH_SQUOTE;
  endfunction

  function automatic bit is_hex_digit(logic [7:0] b);
    return (b >= "0" && b <= "9") || (b >= "a" && b <= "f") || (b >= "A" && b <= "F");
  endfunction

  // the newest token is held back so the final one of an item can be flagged
  task automatic add_token(kind_t k, logic [31:0] s, logic [31:0] e, logic [15:0] w,
                           logic sq);
    if (have_held) tokens_due.push_back(held_tok);
    held_tok.kind = k;
    held_tok.start = s;
    held_tok.stop = e;
    held_tok.indent = w;
    held_tok.sq = sq;
    held_tok.last = 1'b0;
    have_held = 1'b1;
  endtask

  task automatic clear_scan();
    lex_mode = MODE_HEAD;
    cur_pos = '0;
    tok_start = '0;
    col_count = '0;
    single_quote = 1'b0;
    seen_escape = 1'b0;
    lead = HEAD_PLAIN;
    only_hex = 1'b1;
    has_body = 1'b0;
  endtask

  task automatic goto_line_head(logic [31:0] p);
    lex_mode = MODE_HEAD;
    tok_start = p + 32'd1;
    col_count = '0;
  endtask

  task automatic flush_atom(logic [31:0] e);
    kind_t k;
    k = KIND_ATOM;
    if (has_body && only_hex) begin
      if (lead == HEAD_AMP) k = KIND_TAG;
      else if (lead == HEAD_STAR) k = KIND_REF;
    end
    add_token(k, tok_start, e, 16'd0, 1'b0);
  endtask

  task automatic scan_main(logic [7:0] b, logic [31:0] p);
    lex_mode = MODE_MAIN;
    case (b)
      CH_HASH: lex_mode = MODE_COMMENT;
      CH_CR, CH_LF: goto_line_head(p);
      CH_SPACE, CH_TAB, CH_COMMA: ;
      CH_LBRACE, CH_LBRACK: add_token(KIND_OPEN, p, p + 32'd1, 16'd0, b == CH_LBRACK);
      CH_RBRACE, CH_RBRACK: add_token(KIND_CLOSE, p, p + 32'd1, 16'd0, b == CH_RBRACK);
      CH_DOLLAR: add_token(KIND_CONV, p, p + 32'd1, 16'd0, 1'b0);
      CH_COLON: add_token(KIND_MAP, p, p + 32'd1, 16'd0, 1'b0);
      CH_DQUOTE, CH_SQUOTE: begin
        lex_mode = MODE_STRING;
        tok_start = p + 32'd1;
        single_quote = (b == CH_SQUOTE);
        seen_escape = 1'b0;
      end
      CH_DASH: begin
        lex_mode = MODE_DASH;
        tok_start = p;
      end
      default: begin
        lex_mode = MODE_ATOM;
        tok_start = p;
        if (b == CH_AMP) lead = HEAD_AMP;
        else if (b == CH_STAR) lead = HEAD_STAR;
        else lead = HEAD_PLAIN;
        only_hex = 1'b1;
        has_body = 1'b0;
      end
    endcase
  endtask

  task automatic predict_tokens(cmd_t cmd, logic [7:0] b);
    logic [31:0] p;
    logic [16:0] sum;
    p = cur_pos;
    have_held = 1'b0;
    if (cmd == CMD_END) begin
      if (lex_mode == MODE_DASH) add_token(KIND_LIST, tok_start, p, 16'd0, 1'b0);
      else if (lex_mode == MODE_ATOM) flush_atom(p);
      if (lex_mode == MODE_STRING || lex_mode == MODE_STRESC)
        add_token(KIND_ERR_OPEN, tok_start, p, 16'd0, 1'b0);
      else if (lex_mode != MODE_ERROR)
        add_token(KIND_END, p, p, 16'd0, 1'b0);
      clear_scan();
    end else begin
      case (lex_mode)
        MODE_HEAD: begin
          if (b == CH_SPACE || b == CH_TAB) begin
            sum = {1'b0, col_count} + ((b == CH_SPACE) ? 17'd1 : {12'd0, tab_cols});
            col_count = sum[16] ? 16'hFFFF : sum[15:0];
          end else if (b == CH_CR || b == CH_LF) begin
            goto_line_head(p);
          end else if (b == CH_HASH) begin
            lex_mode = MODE_COMMENT;
          end else begin
            add_token(KIND_INDENT, tok_start, p, col_count, 1'b0);
            col_count = '0;
            scan_main(b, p);
          end
        end
        MODE_MAIN: scan_main(b, p);
        MODE_COMMENT: if (b == CH_CR || b == CH_LF) goto_line_head(p);
        MODE_DASH: begin
          if (b != CH_DASH) begin
            if (is_space_byte(b)) begin
              add_token(KIND_LIST, tok_start, p, 16'd0, 1'b0);
              scan_main(b, p);
            end else if (is_separator(b)) begin
              add_token(KIND_ATOM, tok_start, p, 16'd0, 1'b0);
              scan_main(b, p);
            end else begin
              // dashes turn into the head of a plain atom
              lex_mode = MODE_ATOM;
              lead = HEAD_PLAIN;
              only_hex = 1'b1;
              has_body = 1'b1;
            end
          end
        end
        MODE_ATOM: begin
          if (is_separator(b)) begin
            flush_atom(p);
            scan_main(b, p);
          end else begin
            has_body = 1'b1;
            if (!is_hex_digit(b)) only_hex = 1'b0;
          end
        end
        MODE_STRING: begin
          if (b == (single_quote ? CH_SQUOTE : CH_DQUOTE)) begin
            add_token(seen_escape ? KIND_ESCSTRING : KIND_STRING, tok_start, p, 16'd0, 1'b0);
            lex_mode = MODE_MAIN;
          end else if (b == CH_CR || b == CH_LF) begin
            add_token(KIND_ERR_BREAK, tok_start, p, 16'd0, 1'b0);
            lex_mode = MODE_ERROR;
          end else if (b == CH_BSLASH) begin
            seen_escape = 1'b1;
            lex_mode = MODE_STRESC;
          end
        end
        MODE_STRESC: lex_mode = MODE_STRING;
        default: lex_mode = MODE_ERROR;
      endcase
      cur_pos = p + 32'd1;
    end
    if (have_held) begin
      held_tok.last = 1'b1;
      tokens_due.push_back(held_tok);
      have_held = 1'b0;
    end
  endtask

  // ---------------- stimulus ----------------

  // entered and left at a rising edge; the item is taken at the edge it returns on
  task automatic send_item(cmd_t cmd, logic [7:0] b);
    if (!no_idle && $urandom_range(0, 99) < in_gap_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
    in_valid <= 1'b1;
    command <= cmd;
    data_byte <= b;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predict_tokens(cmd, b);
    items_sent++;
  endtask

  task automatic send_byte(logic [7:0] b);
    send_item(CMD_DATA, b);
  endtask

  task automatic send_end();
    send_item(CMD_END, 8'($urandom_range(0, 255)));
  endtask

  task automatic send_text(string s);
    for (int i = 0; i < s.len(); i++) send_byte(s[i]);
  endtask

  // no item in flight and every token drained, plus the queue latency
  task automatic wait_idle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (tokens_due.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic set_tab_width(logic [4:0] w);
    wait_idle();
    tab_width_we <= 1'b1;
    tab_width_wdata <= w;
    @(posedge clk);
    tab_width_we <= 1'b0;
    tab_cols = w;
  endtask

  function automatic logic [7:0] atom_char();
    case ($urandom_range(0, 9))
      0: return 8'("0" + $urandom_range(0, 9));
      1, 2: return 8'("a" + $urandom_range(0, 25));
      3: return 8'("A" + $urandom_range(0, 25));
      4: return "=";
      5: return ($urandom_range(0, 1) != 0) ? "_" : ".";
      6: return ($urandom_range(0, 1) != 0) ? CH_HASH : CH_DASH;
      7: return ($urandom_range(0, 1) != 0) ? CH_AMP : CH_STAR;
      8: return 8'h00;
      default: return 8'($urandom_range(128, 255));
    endcase
  endfunction

  function automatic logic [7:0] hex_char();
    string digits;
    digits = "0123456789abcdefABCDEF";
    return digits[$urandom_range(0, 21)];
  endfunction

  function automatic int pick_pct();
    case ($urandom_range(0, 3))
      0: return 0;
      1: return 10;
      2: return 30;
      default: return 60;
    endcase
  endfunction

  function automatic logic [4:0] pick_width();
    case ($urandom_range(0, 4))
      0: return 5'd0;
      1: return 5'd1;
      2: return 5'd16;
      3: return 5'd31;
      default: return 5'($urandom_range(0, 31));
    endcase
  endfunction

  task automatic gen_element();
    logic [7:0] q;
    case ($urandom_range(0, 9))
      0: begin
        case ($urandom_range(0, 3))
          0: send_byte(CH_LBRACE);
          1: send_byte(CH_RBRACE);
          2: send_byte(CH_LBRACK);
          default: send_byte(CH_RBRACK);
        endcase
      end
      1: send_byte(($urandom_range(0, 1) != 0) ? CH_DOLLAR : CH_COLON);
      2: begin
        repeat ($urandom_range(1, 3)) send_byte(CH_DASH);
        case ($urandom_range(0, 3))
          0: send_byte(($urandom_range(0, 1) != 0) ? CH_SPACE : CH_TAB);
          1: send_byte(($urandom_range(0, 1) != 0) ? CH_COMMA : CH_COLON);
          2: repeat ($urandom_range(1, 3)) send_byte(atom_char());
          default: ;
        endcase
      end
      3, 4: repeat ($urandom_range(1, 6)) send_byte(atom_char());
      5: begin
        send_byte(($urandom_range(0, 1) != 0) ? CH_AMP : CH_STAR);
        repeat ($urandom_range(0, 3)) send_byte(hex_char());
        if ($urandom_range(0, 4) == 0) send_byte(8'("g" + $urandom_range(0, 19)));
      end
      6, 7: begin
        q = ($urandom_range(0, 1) != 0) ? CH_DQUOTE : CH_SQUOTE;
        send_byte(q);
        repeat ($urandom_range(0, 6)) begin
          case ($urandom_range(0, 4))
            0: begin
              // escape may swallow anything, a line break or the quote included
              send_byte(CH_BSLASH);
              send_byte(8'($urandom_range(0, 255)));
            end
            1: send_byte(CH_SPACE);
            2: send_byte((q == CH_DQUOTE) ? CH_SQUOTE : CH_DQUOTE);
            default: send_byte(atom_char());
          endcase
        end
        send_byte(q);
      end
      8: send_byte(8'($urandom_range(0, 255)));
      default: send_byte(($urandom_range(0, 1) != 0) ? "=" : 8'h00);
    endcase
  endtask

  task automatic gen_line(output bit broken);
    int kind_pick;
    int n;
    broken = 1'b0;
    if ($urandom_range(0, 3) != 0)
      repeat ($urandom_range(1, 4))
        send_byte(($urandom_range(0, 2) == 0) ? CH_TAB : CH_SPACE);
    kind_pick = $urandom_range(0, 9);
    if (kind_pick == 1) begin
      send_byte(CH_HASH);
      repeat ($urandom_range(0, 6)) send_byte(8'($urandom_range(32, 255)));
    end else if (kind_pick > 1) begin
      n = $urandom_range(1, 5);
      for (int i = 0; i < n; i++) begin
        if (i > 0) begin
          case ($urandom_range(0, 3))
            0: send_byte(CH_COMMA);
            1: send_byte(CH_TAB);
            default: send_byte(CH_SPACE);
          endcase
        end
        gen_element();
      end
    end
    if ($urandom_range(0, 24) == 0) begin
      send_byte(CH_DQUOTE);
      send_byte("x");
      send_byte(($urandom_range(0, 1) != 0) ? CH_LF : CH_CR);
      broken = 1'b1;
    end else begin
      case ($urandom_range(0, 4))
        0: send_byte(CH_CR);
        1: begin
          send_byte(CH_CR);
          send_byte(CH_LF);
        end
        default: send_byte(CH_LF);
      endcase
    end
  endtask

  task automatic gen_document();
    bit broken;
    int lines;
    broken = 1'b0;
    lines = $urandom_range(1, 6);
    while (lines > 0 && !broken) begin
      gen_line(broken);
      lines--;
    end
    if (broken) begin
      repeat ($urandom_range(0, 3)) send_byte(8'($urandom_range(0, 255)));
    end else if ($urandom_range(0, 9) == 0) begin
      send_byte(CH_SQUOTE);
      send_byte("z");
    end else if ($urandom_range(0, 2) == 0) begin
      gen_element();
    end
    send_end();
  endtask

  // ---------------- tests ----------------

  task automatic test_token_kinds();
    in_gap_pct = 20;
    out_stall_pct = 20;
    send_text("\t[&a,*b:$]{\"\\\"\"'q'}- -,=");
    send_byte(8'h00);
    send_byte(8'hFF);
    send_text("\n#c\n-");
    send_end();
    wait_idle();
  endtask

  task automatic test_string_errors();
    // raw line break in a string, then ignored bytes, then end with no token
    send_text("\"a\nx");
    send_end();
    // end while a string is still open
    send_text("'b");
    send_end();
    wait_idle();
  endtask

  task automatic test_tab_widths();
    logic [4:0] widths[4];
    widths = '{5'd0, 5'd1, 5'd16, 5'd31};
    foreach (widths[i]) begin
      set_tab_width(widths[i]);
      send_text("\t \tx");
      send_end();
    end
    wait_idle();
  endtask

  task automatic test_random_documents();
    int first;
    first = items_sent;
    while (items_sent - first < RANDOM_ITEMS) begin
      if ($urandom_range(0, 3) == 0) set_tab_width(pick_width());
      in_gap_pct = pick_pct();
      out_stall_pct = pick_pct();
      gen_document();
    end
    wait_idle();
  endtask

  task automatic test_no_idle_stream();
    no_idle = 1'b1;
    set_tab_width(pick_width());
    repeat (4) gen_document();
    wait_idle();
  endtask

  initial begin
    clear_scan();
    tab_cols = TAB_WIDTH_RESET;
    have_held = 1'b0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    test_token_kinds();
    test_string_errors();
    test_tab_widths();
    test_random_documents();
    test_no_idle_stream();
    repeat (20) @(posedge clk);
    if (err_count == 0)
      $display("indent_aware_data_tokenizer_unit verification clean");
    else
      $display("indent_aware_data_tokenizer_unit verification failed");
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/core/aidt_pkg.sv
rtl/core/aidt_scan.sv
rtl/core/aidt_queue.sv
rtl/core/indent_aware_data_tokenizer_unit.sv
rtl/core/aidt_checker.sv
verif/tb_top.sv
